FILE: design/cspa_pkg.sv
// ----------------------------------------------------------------------------
// cspa_pkg
// Shared constants, types and the exp2 root table for the gas sensor reading.
// ----------------------------------------------------------------------------
package cspa_pkg;

    localparam int ADC_BITS        = 12;
    localparam int GROUP_LOG2      = 5;
    localparam int SUM_W           = ADC_BITS + GROUP_LOG2;

    localparam int BASE_W          = 16;
    localparam int LEVEL_W         = 18;
    localparam int OHMS_W          = 22;
    localparam int PPM_W           = 18;
    localparam int CFG_IDX_W       = 2;
    localparam int CFG_DATA_W      = 18;

    localparam int DIV_BITS        = 38;
    localparam int DVS_W           = 23;
    localparam int CNT_W           = 6;
    localparam int LOG_STEPS       = 16;

    localparam logic [1:0] REG_BASELINE = 2'd0;
    localparam logic [1:0] REG_ALARM    = 2'd1;
    localparam logic [1:0] REG_CLEAR    = 2'd2;

    localparam logic [BASE_W-1:0]  BASE_RESET  = 16'd1000;
    localparam logic [LEVEL_W-1:0] ALARM_RESET = 18'd80;
    localparam logic [LEVEL_W-1:0] CLEAR_RESET = 18'd32;

    // 6600000 uV over 4095 full scale, reduced by the common factor 15
    localparam logic [18:0] VOLT_NUM     = 19'd440000;
    localparam logic [63:0] VOLT_DEN     = 64'd273;
    localparam int          VOLT_SHIFT   = 40;
    localparam logic [31:0] VOLT_RECIP   =
        32'(((64'd1 << VOLT_SHIFT) + VOLT_DEN - 64'd1) / VOLT_DEN);
    localparam logic [22:0] VOLT_LOW_UV  = 23'd20000;
    localparam logic [22:0] VOLT_HIGH_UV = 23'd4980000;
    localparam logic [22:0] SUPPLY_UV    = 23'd5000000;
    localparam logic [13:0] LOAD_OHMS    = 14'd10000;
    localparam logic [22:0] RATIO_LOW    = 23'd655;
    localparam logic [22:0] RATIO_HIGH   = 23'd6553600;
    localparam logic signed [24:0] EXP_OFFSET = 25'sd696646;
    localparam logic signed [17:0] EXP_COEF   = 18'sd99746;
    localparam logic [PPM_W-1:0]   PPM16_MAX  = 18'd159984;

    typedef enum logic [3:0] {
        OP_IDLE,
        OP_VLOAD,
        OP_VMUL,
        OP_DIV,
        OP_VCLAMP,
        OP_RSLOAD,
        OP_RSCLAMP,
        OP_RATLOAD,
        OP_RATCLAMP,
        OP_NORM,
        OP_LOG,
        OP_SCALE,
        OP_EXPLOAD,
        OP_EXP,
        OP_PUBLISH,
        OP_HOLD
    } op_t;

    typedef struct packed {
        op_t op;
    } cmd_t;

    typedef struct packed {
        logic group_done;
        logic iter_last;
        logic norm_done;
        logic out_busy;
    } stat_t;

    function automatic logic [63:0] isqrt64(input logic [63:0] n_in);
        logic [63:0] n;
        logic [63:0] r;
        logic [63:0] b;
        n = n_in;
        r = '0;
        b = 64'd1 << 62;
        for (int i = 0; i < 32; i++)
        begin
            if (n >= r + b)
            begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end
            else
            begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // Q30 factors 2^(2^-i), i = 1..16, each the root of the one before
    function automatic logic [LOG_STEPS-1:0][30:0] root_table();
        logic [LOG_STEPS-1:0][30:0] tab;
        logic [63:0] c;
        c = 64'd1 << 31;
        for (int i = 0; i < LOG_STEPS; i++)
        begin
            c = isqrt64(c << 30);
            tab[i] = c[30:0];
        end
        return tab;
    endfunction

    localparam logic [LOG_STEPS-1:0][30:0] ROOT_TAB = root_table();

endpackage

FILE: design/co_sensor_ppm_alarm.sv
// ----------------------------------------------------------------------------
// co_sensor_ppm_alarm
// Gas sensor reading: 32-sample mean, resistance, power-law ppm, alarm.
// ----------------------------------------------------------------------------
// Samples are taken one per cycle. The beat that completes a group of 32
// starts a reading, and input stalls while it runs: a reciprocal multiply
// for the voltage, two divisions on one shared bit-per-cycle divider, a
// leading-one search, then 16 log2 squaring steps, 16 exp2 steps and the
// publish cycle. If the previous reading still waits in the output
// register, the stall lasts until it is taken. A finished reading sits in
// the output register while the next group is collected. Configuration
// writes are taken in any cycle (ready stays high).
// ----------------------------------------------------------------------------
module co_sensor_ppm_alarm (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [cspa_pkg::ADC_BITS-1:0]      sample,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [cspa_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [cspa_pkg::CFG_DATA_W-1:0]    cfg_data,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [cspa_pkg::ADC_BITS-1:0]      mean_sample,
    output logic [cspa_pkg::OHMS_W-1:0]        sensor_ohms,
    output logic [cspa_pkg::PPM_W-1:0]         ppm_sixteenths,
    output logic                               alarm,
    output logic                               alarm_changed
);
    import cspa_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    cspa_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .cmd   (cmd)
    );

    cspa_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .sample         (sample),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .mean_sample    (mean_sample),
        .sensor_ohms    (sensor_ohms),
        .ppm_sixteenths (ppm_sixteenths),
        .alarm          (alarm),
        .alarm_changed  (alarm_changed)
    );

endmodule

FILE: design/cspa_ctrl.sv
// ----------------------------------------------------------------------------
// cspa_ctrl
// Sequencer for one reading: voltage, divisions, log2, scaling, exp2, publish.
// ----------------------------------------------------------------------------
module cspa_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  cspa_pkg::stat_t stat,
    output cspa_pkg::cmd_t  cmd
);
    import cspa_pkg::*;

    typedef enum logic [15:0] {
        S_IDLE     = 16'h0001,
        S_VLOAD    = 16'h0002,
        S_VMUL     = 16'h0004,
        S_VCLAMP   = 16'h0008,
        S_RSLOAD   = 16'h0010,
        S_RSDIV    = 16'h0020,
        S_RSCLAMP  = 16'h0040,
        S_RATLOAD  = 16'h0080,
        S_RATDIV   = 16'h0100,
        S_RATCLAMP = 16'h0200,
        S_NORM     = 16'h0400,
        S_LOG      = 16'h0800,
        S_SCALE    = 16'h1000,
        S_EXPLOAD  = 16'h2000,
        S_EXP      = 16'h4000,
        S_PUBLISH  = 16'h8000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd.op     = OP_IDLE;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.op = OP_IDLE;
                if (stat.group_done)
                    state_next = S_VLOAD;
            end
            S_VLOAD:
            begin
                cmd.op     = OP_VLOAD;
                state_next = S_VMUL;
            end
            S_VMUL:
            begin
                cmd.op     = OP_VMUL;
                state_next = S_VCLAMP;
            end
            S_VCLAMP:
            begin
                cmd.op     = OP_VCLAMP;
                state_next = S_RSLOAD;
            end
            S_RSLOAD:
            begin
                cmd.op     = OP_RSLOAD;
                state_next = S_RSDIV;
            end
            S_RSDIV:
            begin
                cmd.op = OP_DIV;
                if (stat.iter_last)
                    state_next = S_RSCLAMP;
            end
            S_RSCLAMP:
            begin
                cmd.op     = OP_RSCLAMP;
                state_next = S_RATLOAD;
            end
            S_RATLOAD:
            begin
                cmd.op     = OP_RATLOAD;
                state_next = S_RATDIV;
            end
            S_RATDIV:
            begin
                cmd.op = OP_DIV;
                if (stat.iter_last)
                    state_next = S_RATCLAMP;
            end
            S_RATCLAMP:
            begin
                cmd.op     = OP_RATCLAMP;
                state_next = S_NORM;
            end
            S_NORM:
            begin
                cmd.op = OP_NORM;
                if (stat.norm_done)
                    state_next = S_LOG;
            end
            S_LOG:
            begin
                cmd.op = OP_LOG;
                if (stat.iter_last)
                    state_next = S_SCALE;
            end
            S_SCALE:
            begin
                cmd.op     = OP_SCALE;
                state_next = S_EXPLOAD;
            end
            S_EXPLOAD:
            begin
                cmd.op     = OP_EXPLOAD;
                state_next = S_EXP;
            end
            S_EXP:
            begin
                cmd.op = OP_EXP;
                if (stat.iter_last)
                    state_next = S_PUBLISH;
            end
            S_PUBLISH:
            begin
                // hold until the output register is free
                if (!stat.out_busy)
                begin
                    cmd.op     = OP_PUBLISH;
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd.op = OP_HOLD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

FILE: design/cspa_dp.sv
// ----------------------------------------------------------------------------
// cspa_dp
// Datapath: sample accumulator, shared restoring divider, log2/exp2 units,
// alarm hysteresis, configuration and output registers.
// ----------------------------------------------------------------------------
module cspa_dp (
    input  logic                               clk,
    input  logic                               rst_n,
    input  cspa_pkg::cmd_t                     cmd,
    output cspa_pkg::stat_t                    stat,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [cspa_pkg::ADC_BITS-1:0]      sample,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [cspa_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [cspa_pkg::CFG_DATA_W-1:0]    cfg_data,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [cspa_pkg::ADC_BITS-1:0]      mean_sample,
    output logic [cspa_pkg::OHMS_W-1:0]        sensor_ohms,
    output logic [cspa_pkg::PPM_W-1:0]         ppm_sixteenths,
    output logic                               alarm,
    output logic                               alarm_changed
);
    import cspa_pkg::*;

    logic [BASE_W-1:0]    base_reg;
    logic [LEVEL_W-1:0]   alarm_lvl_reg;
    logic [LEVEL_W-1:0]   clear_lvl_reg;

    logic [SUM_W-1:0]     sum_reg;
    logic [GROUP_LOG2-1:0] count_reg;
    logic [ADC_BITS-1:0]  mean_reg;

    logic [DIV_BITS-1:0]  dq_reg;
    logic [DVS_W-1:0]     rem_reg;
    logic [DVS_W-1:0]     dvs_reg;
    logic [CNT_W-1:0]     cnt_reg;

    logic [22:0]          v_reg;
    logic [OHMS_W-1:0]    rs_reg;
    logic [31:0]          x_reg;
    logic [4:0]           p_reg;
    logic [30:0]          m_reg;
    logic [15:0]          frac_reg;
    logic signed [37:0]   prod_reg;
    logic [15:0]          f_reg;
    logic [7:0]           k_reg;
    logic                 eneg_reg;
    logic                 alarm_reg;

    logic                 out_valid_reg;
    logic [ADC_BITS-1:0]  out_mean_reg;
    logic [OHMS_W-1:0]    out_ohms_reg;
    logic [PPM_W-1:0]     out_ppm_reg;
    logic                 out_alarm_reg;
    logic                 out_changed_reg;

    logic                 accept;
    logic [SUM_W-1:0]     sum_add;
    logic [DVS_W:0]       rem_sh;
    logic                 rem_ge;
    logic [DVS_W:0]       rem_diff;
    logic [30:0]          vnum;
    logic [62:0]          vprod;
    logic [22:0]          vdiff;
    logic [36:0]          rsnum;
    logic [22:0]          vclamp;
    logic [OHMS_W-1:0]    rsclamp;
    logic [22:0]          ratclamp;
    logic [61:0]          sq;
    logic [31:0]          sq_t;
    logic [3:0]           pm16;
    logic signed [19:0]   lval;
    logic signed [37:0]   prod_adj;
    logic signed [21:0]   qval;
    logic signed [24:0]   eval;
    logic [61:0]          mc;
    logic [4:0]           shamt;
    logic [30:0]          rshift;
    logic [PPM_W-1:0]     ppm;
    logic                 alarm_new;
    logic                 iter_op;

    assign cfg_ready = 1'b1;
    assign in_stall  = (cmd.op != OP_IDLE);
    assign accept    = in_valid && !in_stall;
    assign sum_add   = sum_reg + SUM_W'(sample);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg      <= BASE_RESET;
            alarm_lvl_reg <= ALARM_RESET;
            clear_lvl_reg <= CLEAR_RESET;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == REG_BASELINE)
                base_reg <= cfg_data[BASE_W-1:0];
            else if (cfg_index == REG_ALARM)
                alarm_lvl_reg <= cfg_data[LEVEL_W-1:0];
            else if (cfg_index == REG_CLEAR)
                clear_lvl_reg <= cfg_data[LEVEL_W-1:0];
        end
    end

    // group accumulator; the last beat of a group latches the floor mean
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg   <= '0;
            count_reg <= '0;
        end
        else if (accept)
        begin
            count_reg <= count_reg + 1'b1;
            if (count_reg == '1)
                sum_reg <= '0;
            else
                sum_reg <= sum_add;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && count_reg == '1)
            mean_reg <= sum_add[SUM_W-1:GROUP_LOG2];
    end

    assign iter_op = (cmd.op == OP_DIV) || (cmd.op == OP_LOG) || (cmd.op == OP_EXP);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else if (iter_op)
            cnt_reg <= cnt_reg + 1'b1;
        else
            cnt_reg <= '0;
    end

    assign stat.group_done = accept && (count_reg == '1);
    assign stat.iter_last  = ((cmd.op == OP_DIV) && (cnt_reg == CNT_W'(DIV_BITS - 1))) ||
                             (((cmd.op == OP_LOG) || (cmd.op == OP_EXP)) &&
                              (cnt_reg == CNT_W'(LOG_STEPS - 1)));
    assign stat.norm_done  = (cmd.op == OP_NORM) && x_reg[31];
    assign stat.out_busy   = out_valid_reg && out_stall;

    // divider step and operand forming
    assign rem_sh   = {rem_reg, dq_reg[DIV_BITS-1]};
    assign rem_ge   = rem_sh >= {1'b0, dvs_reg};
    assign rem_diff = rem_sh - {1'b0, dvs_reg};

    // voltage: floor divide by the constant denominator through its reciprocal
    assign vnum  = 31'(mean_reg) * 31'(VOLT_NUM);
    assign vprod = 63'(dq_reg[30:0]) * 63'(VOLT_RECIP);
    assign vdiff = SUPPLY_UV - v_reg;
    assign rsnum = 37'(LOAD_OHMS) * 37'(vdiff);

    always_comb
    begin
        priority if (dq_reg < DIV_BITS'(VOLT_LOW_UV))
            vclamp = VOLT_LOW_UV;
        else if (dq_reg > DIV_BITS'(VOLT_HIGH_UV))
            vclamp = VOLT_HIGH_UV;
        else
            vclamp = dq_reg[22:0];
    end

    assign rsclamp = (dq_reg == '0) ? OHMS_W'(1) : dq_reg[OHMS_W-1:0];

    always_comb
    begin
        priority if (dq_reg < DIV_BITS'(RATIO_LOW))
            ratclamp = RATIO_LOW;
        else if (dq_reg > DIV_BITS'(RATIO_HIGH))
            ratclamp = RATIO_HIGH;
        else
            ratclamp = dq_reg[22:0];
    end

    // log2 fraction: square the Q30 mantissa, pull out one bit
    assign sq   = 62'(m_reg) * 62'(m_reg);
    assign sq_t = sq[61:30];
    assign pm16 = 4'(p_reg - 5'd16);
    assign lval = {pm16, frac_reg};

    // trunc toward zero of prod / 2^16
    assign prod_adj = prod_reg[37] ? (prod_reg + 38'sd65535) : prod_reg;
    assign qval     = prod_adj[37:16];
    assign eval     = EXP_OFFSET - {{3{qval[21]}}, qval};

    assign mc = 62'(m_reg) * 62'(ROOT_TAB[cnt_reg[3:0]]);

    assign shamt  = 5'(6'd30 - 6'(k_reg[4:0]));
    assign rshift = m_reg >> shamt;

    always_comb
    begin
        priority if (eneg_reg)
            ppm = '0;
        else if (k_reg >= 8'd18)
            ppm = PPM16_MAX;
        else if (rshift > 31'(PPM16_MAX))
            ppm = PPM16_MAX;
        else
            ppm = rshift[PPM_W-1:0];
    end

    assign alarm_new = alarm_reg ? !(ppm < clear_lvl_reg) : (ppm >= alarm_lvl_reg);

    always_ff @(posedge clk)
    begin
        unique case (cmd.op)
            OP_VLOAD:
            begin
                dq_reg <= DIV_BITS'(vnum);
            end
            OP_VMUL:
            begin
                dq_reg <= DIV_BITS'(vprod[62:VOLT_SHIFT]);
            end
            OP_DIV:
            begin
                dq_reg  <= {dq_reg[DIV_BITS-2:0], rem_ge};
                rem_reg <= rem_ge ? rem_diff[DVS_W-1:0] : rem_sh[DVS_W-1:0];
            end
            OP_VCLAMP:
            begin
                v_reg <= vclamp;
            end
            OP_RSLOAD:
            begin
                dq_reg  <= DIV_BITS'(rsnum);
                rem_reg <= '0;
                dvs_reg <= v_reg;
            end
            OP_RSCLAMP:
            begin
                rs_reg <= rsclamp;
            end
            OP_RATLOAD:
            begin
                dq_reg  <= {rs_reg, 16'd0};
                rem_reg <= '0;
                dvs_reg <= (base_reg == '0) ? DVS_W'(1) : DVS_W'(base_reg);
            end
            OP_RATCLAMP:
            begin
                x_reg <= 32'(ratclamp);
                p_reg <= 5'd31;
            end
            OP_NORM:
            begin
                if (x_reg[31])
                begin
                    m_reg    <= x_reg[31:1];
                    frac_reg <= '0;
                end
                else
                begin
                    x_reg <= {x_reg[30:0], 1'b0};
                    p_reg <= p_reg - 1'b1;
                end
            end
            OP_LOG:
            begin
                m_reg    <= sq_t[31] ? sq_t[31:1] : sq_t[30:0];
                frac_reg <= {frac_reg[14:0], sq_t[31]};
            end
            OP_SCALE:
            begin
                prod_reg <= EXP_COEF * lval;
            end
            OP_EXPLOAD:
            begin
                eneg_reg <= eval[24];
                k_reg    <= eval[23:16];
                f_reg    <= eval[15:0];
                m_reg    <= 31'd1 << 30;
            end
            OP_EXP:
            begin
                if (f_reg[15])
                    m_reg <= mc[60:30];
                f_reg <= {f_reg[14:0], 1'b0};
            end
            OP_IDLE, OP_PUBLISH, OP_HOLD:
            begin
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alarm_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (cmd.op == OP_PUBLISH)
        begin
            alarm_reg     <= alarm_new;
            out_valid_reg <= 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_PUBLISH)
        begin
            out_mean_reg    <= mean_reg;
            out_ohms_reg    <= rs_reg;
            out_ppm_reg     <= ppm;
            out_alarm_reg   <= alarm_new;
            out_changed_reg <= alarm_new ^ alarm_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign mean_sample    = out_mean_reg;
    assign sensor_ohms    = out_ohms_reg;
    assign ppm_sixteenths = out_ppm_reg;
    assign alarm          = out_alarm_reg;
    assign alarm_changed  = out_changed_reg;

endmodule
